@@ design/i2c_master_write_read_sequencer_assert.svh @@
// assertion macros used by the checker file
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_ASSERT_SVH

// plain property, checked on every rising clock edge outside reset
`define I2CSEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("i2cseq assertion failed");

// implication into the next cycle
`define I2CSEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("i2cseq assertion failed");

`endif

@@ design/i2cseq_pkg.sv @@
`timescale 1ns / 1ps
package i2cseq_pkg;

  localparam logic [7:0] ReadLenMax = 8'd255;
  localparam logic [7:0] ReadBit    = 8'h01;

  typedef enum logic [1:0] {
    FuncStart  = 2'd0,
    FuncBus    = 2'd1,
    FuncCancel = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    StStart      = 4'd0,
    StRepStart   = 4'd1,
    StMtSlaAck   = 4'd2,
    StMtDataAck  = 4'd3,
    StMtSlaNack  = 4'd4,
    StMtDataNack = 4'd5,
    StArbLost    = 4'd6,
    StMrSlaAck   = 4'd7,
    StMrSlaNack  = 4'd8,
    StMrDataAck  = 4'd9,
    StMrDataNack = 4'd10,
    StBusError   = 4'd11,
    StOther      = 4'd12
  } bus_status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] slave_addr;
    logic [7:0] read_length;
    logic [3:0] bus_status;
    logic [7:0] rx_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic        send_start;
    logic        send_stop;
    logic        send_ack;
    logic        keep_going;
    logic [7:0]  bus_byte;
    logic        bus_byte_valid;
    logic        take_tx;
    logic        store_valid;
    logic [7:0]  store_byte;
    logic        request_done;
    logic [15:0] error_total;
    logic        start_refused;
  } out_t;

  typedef struct packed {
    logic        busy;
    logic        read_pending;
    logic [7:0]  target_address;
    logic [7:0]  read_room;
    logic [15:0] error_count;
  } state_t;

endpackage

@@ design/i2cseq_in_if.sv @@
`timescale 1ns / 1ps
interface i2cseq_in_if;
  import i2cseq_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/i2cseq_out_if.sv @@
`timescale 1ns / 1ps
interface i2cseq_out_if;
  import i2cseq_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/i2cseq_core.sv @@
`timescale 1ns / 1ps
module i2cseq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  i2cseq_pkg::in_t    item_i,
  output i2cseq_pkg::out_t   result_o
);
  import i2cseq_pkg::*;

  state_t state_q, state_d;
  out_t   res;

  always_comb begin
    logic [7:0] room_after;
    room_after = state_q.read_room;
    state_d    = state_q;
    res        = '0;
    unique case (item_i.func)
      FuncStart: begin
        if (state_q.busy) begin
          res.start_refused = 1'b1;
        end else begin
          state_d.target_address = item_i.slave_addr;
          state_d.read_pending   = (item_i.read_length != 8'd0);
          state_d.read_room      = (item_i.read_length > ReadLenMax) ? ReadLenMax
                                                                     : item_i.read_length;
          state_d.busy           = 1'b1;
          res.send_start         = 1'b1;
          res.keep_going         = 1'b1;
        end
      end
      FuncBus: begin
        if (state_q.busy) begin
          // received byte goes to the buffer only while room remains
          if ((item_i.bus_status == StMrDataAck || item_i.bus_status == StMrDataNack)
              && state_q.read_room != 8'd0) begin
            res.store_valid = 1'b1;
            res.store_byte  = item_i.rx_byte;
            room_after      = state_q.read_room - 8'd1;
          end
          state_d.read_room = room_after;
          unique case (item_i.bus_status)
            StStart: begin
              res.bus_byte       = state_q.target_address;
              res.bus_byte_valid = 1'b1;
              res.keep_going     = 1'b1;
            end
            StRepStart: begin
              res.bus_byte       = state_q.read_pending ? (state_q.target_address | ReadBit)
                                                        : state_q.target_address;
              res.bus_byte_valid = 1'b1;
              res.keep_going     = 1'b1;
            end
            StMtSlaAck, StMtDataAck: begin
              if (item_i.tx_valid) begin
                res.bus_byte       = item_i.tx_byte;
                res.bus_byte_valid = 1'b1;
                res.take_tx        = 1'b1;
                res.keep_going     = 1'b1;
              end else if (state_q.read_pending) begin
                res.send_start = 1'b1;
                res.keep_going = 1'b1;
              end else begin
                res.send_stop    = 1'b1;
                res.request_done = 1'b1;
                state_d.busy     = 1'b0;
              end
            end
            StArbLost: begin
              state_d.error_count = state_q.error_count + 16'd1;
              res.send_start      = 1'b1;
              res.keep_going      = 1'b1;
            end
            StMrSlaAck, StMrDataAck: begin
              res.send_ack   = (room_after > 8'd1);
              res.keep_going = 1'b1;
            end
            StMrDataNack: begin
              res.send_stop    = 1'b1;
              res.request_done = 1'b1;
              state_d.busy     = 1'b0;
            end
            default: begin
              // address nacks, write data nacks, bus error and unknown codes
              state_d.error_count = state_q.error_count + 16'd1;
              res.send_stop       = 1'b1;
              res.request_done    = 1'b1;
              state_d.busy        = 1'b0;
            end
          endcase
        end
      end
      FuncCancel: begin
        state_d.read_pending = 1'b0;
      end
      default: begin
      end
    endcase
    res.error_total = state_d.error_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  assign result_o = res;

endmodule

@@ design/i2cseq_out_reg.sv @@
`timescale 1ns / 1ps
module i2cseq_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  i2cseq_pkg::out_t  result_i,
  output logic              room_o,
  i2cseq_out_if.source      out_o
);
  import i2cseq_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // free when empty or when the held result transfers this cycle
  assign room_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

@@ design/i2c_master_write_read_sequencer.sv @@
`timescale 1ns / 1ps
// I2C write-then-read transaction sequencer. Every input transfer (start
// request, bus status event, read cancel or unused code) yields exactly
// one result, in the cycle after it is taken: the sequencing logic works
// straight from the input and the current state into a single output
// register, so it takes one item per cycle unless the output stalls. Input
// ready is high while that register is empty or its result transfers in
// the same cycle; a stalled result holds further input until it is taken.
module i2c_master_write_read_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cseq_in_if.sink   in_i,
  i2cseq_out_if.source out_o
);
  import i2cseq_pkg::*;

  logic room;
  logic accept;
  out_t result;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  i2cseq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.data),
    .result_o (result)
  );

  i2cseq_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .room_o   (room),
    .out_o    (out_o)
  );

endmodule

@@ design/i2cseq_checker.sv @@
`timescale 1ns / 1ps
`include "i2c_master_write_read_sequencer_assert.svh"
module i2cseq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input i2cseq_pkg::out_t out_data_i
);
  import i2cseq_pkg::*;

  logic out_stall;
  logic in_take;
  logic refused_quiet;
  logic start_stop_apart;

  assign out_stall        = out_valid_i && !out_ready_i;
  assign in_take          = in_valid_i && in_ready_i;
  assign refused_quiet    = !out_data_i.start_refused ||
                            (!out_data_i.send_start && !out_data_i.keep_going &&
                             !out_data_i.bus_byte_valid);
  assign start_stop_apart = !(out_data_i.send_start && out_data_i.send_stop);

  // held result stays until it transfers
  `I2CSEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_data_i))

  // an empty output stage never blocks input
  `I2CSEQ_ASSERT(a_ready_when_empty, clk_i, rst_ni, out_valid_i || in_ready_i)

  // each taken item shows a result next cycle
  `I2CSEQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_take, out_valid_i)

  // a refused start does nothing on the bus, and start never pairs with stop
  `I2CSEQ_ASSERT(a_refused_quiet, clk_i, rst_ni, !out_valid_i || (refused_quiet && start_stop_apart))

endmodule

bind i2c_master_write_read_sequencer i2cseq_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import i2cseq_pkg::*;

  localparam logic [1:0] FuncUnused   = 2'd3;
  localparam logic [3:0] StMaxCode    = 4'hF;
  localparam int         RandomItems  = 1950;
  localparam int         MaxGap       = 17;
  localparam int         IdleLimit    = 1000;
  localparam int         DrainCycles  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2cseq_in_if  in_if ();
  i2cseq_out_if out_if ();

  i2c_master_write_read_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_t  stimulus_q[$];
  out_t expected_results[$];

  // predicted sequencer state
  logic        seq_busy;
  logic        seq_read_pending;
  logic [7:0]  seq_target;
  logic [7:0]  seq_room;
  logic [15:0] seq_errors;

  bit failed;
  int sent_count, checked_count, done_count, stored_count, refused_count;
  int in_wait, in_run, out_wait, out_run, out_gap, idle_cycles;
  bit in_calm, out_calm;
  out_t exp_res;

  function automatic out_t compute_result(in_t item);
    out_t res;
    res = '0;
    case (item.func)
      FuncStart: begin
        if (seq_busy) begin
          res.start_refused = 1'b1;
        end else begin
          seq_target       = item.slave_addr;
          seq_read_pending = (item.read_length != 8'd0);
          seq_room         = (item.read_length > ReadLenMax) ? ReadLenMax : item.read_length;
          seq_busy         = 1'b1;
          res.send_start   = 1'b1;
          res.keep_going   = 1'b1;
        end
      end
      FuncBus: begin
        if (seq_busy) begin
          case (item.bus_status)
            StStart: begin
              res.bus_byte       = seq_target;
              res.bus_byte_valid = 1'b1;
              res.keep_going     = 1'b1;
            end
            StRepStart: begin
              res.bus_byte       = seq_read_pending ? (seq_target | ReadBit) : seq_target;
              res.bus_byte_valid = 1'b1;
              res.keep_going     = 1'b1;
            end
            StMtSlaAck, StMtDataAck: begin
              if (item.tx_valid) begin
                res.bus_byte       = item.tx_byte;
                res.bus_byte_valid = 1'b1;
                res.take_tx        = 1'b1;
                res.keep_going     = 1'b1;
              end else if (seq_read_pending) begin
                res.send_start = 1'b1;
                res.keep_going = 1'b1;
              end else begin
                res.send_stop    = 1'b1;
                res.request_done = 1'b1;
                seq_busy         = 1'b0;
              end
            end
            StArbLost: begin
              seq_errors     = seq_errors + 16'd1;
              res.send_start = 1'b1;
              res.keep_going = 1'b1;
            end
            StMrSlaAck: begin
              res.send_ack   = (seq_room > 8'd1);
              res.keep_going = 1'b1;
            end
            StMrDataAck: begin
              if (seq_room != 8'd0) begin
                res.store_valid = 1'b1;
                res.store_byte  = item.rx_byte;
                seq_room        = seq_room - 8'd1;
              end
              res.send_ack   = (seq_room > 8'd1);
              res.keep_going = 1'b1;
            end
            StMrDataNack: begin
              // last byte may still land if room is left
              if (seq_room != 8'd0) begin
                res.store_valid = 1'b1;
                res.store_byte  = item.rx_byte;
                seq_room        = seq_room - 8'd1;
              end
              res.send_stop    = 1'b1;
              res.request_done = 1'b1;
              seq_busy         = 1'b0;
            end
            default: begin
              seq_errors       = seq_errors + 16'd1;
              res.send_stop    = 1'b1;
              res.request_done = 1'b1;
              seq_busy         = 1'b0;
            end
          endcase
        end
      end
      FuncCancel: begin
        seq_read_pending = 1'b0;
      end
      default: begin
      end
    endcase
    res.error_total = seq_errors;
    return res;
  endfunction

  function automatic in_t random_fill();
    logic [63:0] raw;
    in_t item;
    raw  = {$urandom, $urandom};
    item = raw[$bits(in_t)-1:0];
    return item;
  endfunction

  function automatic in_t start_item(logic [7:0] addr, logic [7:0] len);
    in_t item;
    item = random_fill();
    item.func        = FuncStart;
    item.slave_addr  = addr;
    item.read_length = len;
    return item;
  endfunction

  function automatic in_t bus_item(logic [3:0] st, logic txv, logic [7:0] rx, logic [7:0] txb);
    in_t item;
    item = random_fill();
    item.func       = FuncBus;
    item.bus_status = st;
    item.tx_valid   = txv;
    item.rx_byte    = rx;
    item.tx_byte    = txb;
    return item;
  endfunction

  function automatic in_t cancel_item();
    in_t item;
    item = random_fill();
    item.func = FuncCancel;
    return item;
  endfunction

  // one write-only or write-then-read transaction, sometimes broken or disturbed
  task automatic add_transaction();
    in_t steps[$];
    in_t item;
    logic [7:0] addr;
    logic [7:0] len;
    logic [3:0] stop_code;
    logic [3:0] nack_codes[4];
    int writes, reads, pos, pick;
    nack_codes = '{StMtSlaNack, StMtDataNack, StMrSlaNack, StBusError};
    addr = 8'($urandom);
    if ($urandom_range(0, 4) != 0) addr[0] = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 30) len = 8'd0;
    else if (pick < 90) len = 8'($urandom_range(1, 5));
    else if (pick < 98) len = 8'($urandom_range(6, 40));
    else len = 8'($urandom_range(200, 255));
    writes = $urandom_range(0, 4);
    steps.push_back(start_item(addr, len));
    steps.push_back(bus_item(StStart, 1'($urandom), 8'($urandom), 8'($urandom)));
    for (int i = 0; i <= writes; i++) begin
      steps.push_back(bus_item((i == 0) ? StMtSlaAck : StMtDataAck, (i < writes),
                               8'($urandom), 8'($urandom)));
    end
    if (len != 8'd0) begin
      steps.push_back(bus_item(StRepStart, 1'($urandom), 8'($urandom), 8'($urandom)));
      steps.push_back(bus_item(StMrSlaAck, 1'($urandom), 8'($urandom), 8'($urandom)));
      pick = $urandom_range(0, 9);
      if (pick == 0) reads = len + $urandom_range(1, 2);   // read past the room
      else if (pick == 1) reads = $urandom_range(1, len);  // nack at or before the last byte of room
      else reads = len;
      for (int k = 1; k < reads; k++) begin
        steps.push_back(bus_item(StMrDataAck, 1'($urandom), 8'($urandom), 8'($urandom)));
      end
      steps.push_back(bus_item(StMrDataNack, 1'($urandom), 8'($urandom), 8'($urandom)));
    end
    if ($urandom_range(0, 99) < 15) begin
      pos = $urandom_range(1, steps.size() - 1);
      while (steps.size() > pos) void'(steps.pop_back());
      pick = $urandom_range(0, 7);
      if (pick < 4) stop_code = nack_codes[pick];
      else stop_code = StOther + 4'(pick - 4);
      steps.push_back(bus_item(stop_code, 1'($urandom), 8'($urandom), 8'($urandom)));
    end
    if ($urandom_range(0, 9) == 0) steps.insert($urandom_range(1, steps.size() - 1), cancel_item());
    if ($urandom_range(0, 9) == 0) begin
      item = bus_item(StArbLost, 1'($urandom), 8'($urandom), 8'($urandom));
      steps.insert($urandom_range(1, steps.size() - 1), item);
    end
    if ($urandom_range(0, 9) == 0) begin
      item = start_item(8'($urandom), 8'($urandom));
      steps.insert($urandom_range(1, steps.size() - 1), item);
    end
    if ($urandom_range(0, 9) == 0) stimulus_q.push_back(random_fill());
    foreach (steps[i]) stimulus_q.push_back(steps[i]);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.data       <= '0;
      in_wait          <= 0;
      in_run            = 0;
      seq_busy          = 1'b0;
      seq_read_pending  = 1'b0;
      seq_target        = '0;
      seq_room          = '0;
      seq_errors        = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(compute_result(in_if.data));
        sent_count++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_wait != 0) begin
          in_if.valid <= 1'b0;
          in_wait     <= in_wait - 1;
        end else if (stimulus_q.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= stimulus_q.pop_front();
          if (in_run == 0) begin
            in_calm = ($urandom_range(0, 2) == 0);
            in_run  = $urandom_range(20, 120);
          end
          in_run--;
          in_wait <= in_calm ? 0 : $urandom_range(0, MaxGap);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_wait     <= 0;
      out_run       = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no input pending: 0x%0h", out_if.data);
          failed = 1'b1;
        end else begin
          exp_res = expected_results.pop_front();
          compare_field("send_start", exp_res.send_start, out_if.data.send_start);
          compare_field("send_stop", exp_res.send_stop, out_if.data.send_stop);
          compare_field("send_ack", exp_res.send_ack, out_if.data.send_ack);
          compare_field("keep_going", exp_res.keep_going, out_if.data.keep_going);
          compare_field("bus_byte", exp_res.bus_byte, out_if.data.bus_byte);
          compare_field("bus_byte_valid", exp_res.bus_byte_valid, out_if.data.bus_byte_valid);
          compare_field("take_tx", exp_res.take_tx, out_if.data.take_tx);
          compare_field("store_valid", exp_res.store_valid, out_if.data.store_valid);
          compare_field("store_byte", exp_res.store_byte, out_if.data.store_byte);
          compare_field("request_done", exp_res.request_done, out_if.data.request_done);
          compare_field("error_total", exp_res.error_total, out_if.data.error_total);
          compare_field("start_refused", exp_res.start_refused, out_if.data.start_refused);
          checked_count++;
          if (exp_res.request_done) done_count++;
          if (exp_res.store_valid) stored_count++;
          if (exp_res.start_refused) refused_count++;
        end
        if (out_run == 0) begin
          out_calm = ($urandom_range(0, 2) == 0);
          out_run  = $urandom_range(20, 120);
        end
        out_run--;
        out_gap = out_calm ? 0 : $urandom_range(0, MaxGap);
        out_if.ready <= (out_gap == 0);
        out_wait     <= out_gap;
      end else if (out_wait != 0) begin
        out_wait     <= out_wait - 1;
        out_if.ready <= (out_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no transfer for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;

    // idle events, unused code, cancel with nothing pending
    stimulus_q.push_back(bus_item(StStart, 1'b1, 8'hFF, 8'hFF));
    begin
      in_t odd;
      odd = random_fill();
      odd.func = FuncUnused;
      stimulus_q.push_back(odd);
    end
    stimulus_q.push_back(cancel_item());
    // longest read, refused start, arbitration loss in the middle
    stimulus_q.push_back(start_item(8'hFE, 8'hFF));
    stimulus_q.push_back(start_item(8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StStart, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMtSlaAck, 1'b1, 8'h00, 8'hFF));
    stimulus_q.push_back(bus_item(StMtDataAck, 1'b0, 8'hFF, 8'h00));
    stimulus_q.push_back(bus_item(StArbLost, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StRepStart, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMrSlaAck, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMrDataAck, 1'b0, 8'hFF, 8'h00));
    stimulus_q.push_back(bus_item(StMrDataNack, 1'b0, 8'h00, 8'h00));
    // one byte of room: nack right away, first byte stored, then a byte with no room dropped
    stimulus_q.push_back(start_item(8'h00, 8'h01));
    stimulus_q.push_back(bus_item(StStart, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMtSlaAck, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMrSlaAck, 1'b0, 8'h00, 8'h00));
    stimulus_q.push_back(bus_item(StMrDataAck, 1'b0, 8'hA5, 8'h00));
    stimulus_q.push_back(bus_item(StMrDataNack, 1'b0, 8'h5A, 8'h00));
    // cancel turns the end of writes into a stop
    stimulus_q.push_back(start_item(8'h55, 8'h03));
    stimulus_q.push_back(cancel_item());
    stimulus_q.push_back(bus_item(StMtSlaAck, 1'b0, 8'h00, 8'h00));
    // status code past the defined list
    stimulus_q.push_back(start_item(8'h7E, 8'h00));
    stimulus_q.push_back(bus_item(StMaxCode, 1'b1, 8'hFF, 8'hFF));

    while (stimulus_q.size() < RandomItems + 24) add_transaction();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus_q.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
    end
    $display("covered %0d input transfers, %0d results checked, %0d transactions closed",
             sent_count, checked_count, done_count);
    $display("%0d bytes stored, %0d starts refused, error total %0d",
             stored_count, refused_count, seq_errors);
    if (!failed && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
